### sv/assert_macros.svh
// Assertion helpers for the checker file sdrpq_check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define SDRPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define SDRPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### sv/sdrpq_pkg.sv
`timescale 1ns / 1ps

package sdrpq_pkg;

    localparam int FB        = 30;
    localparam int E_W       = 6;
    localparam int LOG_W     = E_W + FB;
    localparam int LOG_LAT   = FB + 1;
    localparam int EXP_LAT   = FB + 1;
    localparam int WHITE_W   = 14;
    localparam int AM_W      = 38;
    localparam int DM_W      = 43;
    localparam int ND_W      = 35;

    localparam logic [11:0] C2_Q7  = 12'd2413;
    localparam logic [11:0] C3_Q7  = 12'd2392;
    localparam logic [11:0] M1_Q14 = 12'd2610;
    localparam logic [11:0] M2_Q5  = 12'd2523;
    localparam logic [ND_W-1:0] NUM_BASE = 35'd897581056;
    localparam logic [ND_W-1:0] DEN_BASE = 35'd1073741824;
    localparam logic [63:0] PEAK_NITS = 64'd10000;

    // Divide by five: floor reciprocal plus one correction step.
    localparam int          DIV_SPLIT = 20;
    localparam logic [21:0] RECIP5    = 22'd3355443;
    localparam int          RECIP5_SH = 24;
    localparam logic [17:0] HI5       = 18'd209715;

    typedef enum logic [0:0] {
        CFG_WHITE_LEVEL = 1'b0,
        CFG_HDR_ACTIVE  = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic hdr;
        logic zero;
    } side_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] bitv;
        n    = n_in;
        r    = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (bitv > n)
            begin
                bitv = bitv >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bitv != 0)
            begin
                if (n >= r + bitv)
                begin
                    n = n - (r + bitv);
                    r = (r >> 1) + bitv;
                end
                else
                begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return r;
    endfunction

    // Root 2^(-2^-k) in Q0.30.
    function automatic logic [FB:0] exp_h(input int k);
        logic [63:0] h;
        h = 64'd1 << (FB - 1);
        for (int j = 1; j <= k; j++)
        begin
            h = isqrt64(h << FB);
        end
        return h[FB:0];
    endfunction

    function automatic logic [LOG_W-1:0] log2_q(input logic [63:0] v);
        logic [63:0]   m;
        logic [FB-1:0] frac;
        logic [E_W-1:0] e;
        e    = '0;
        frac = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                e = E_W'(i);
            end
        end
        if (e > E_W'(FB))
        begin
            m = v >> (e - E_W'(FB));
        end
        else
        begin
            m = v << (E_W'(FB) - e);
        end
        for (int i = 0; i < FB; i++)
        begin
            m    = (m * m) >> FB;
            frac = {frac[FB-2:0], 1'b0};
            if (m >= (64'd2 << FB))
            begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        if (v == 0)
        begin
            return '0;
        end
        return {e, frac};
    endfunction

endpackage

### sv/sdrpq_log2.sv
`timescale 1ns / 1ps

module sdrpq_log2 #(
    parameter int VW = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [VW-1:0]               v,
    output logic [sdrpq_pkg::LOG_W-1:0] l
);
    import sdrpq_pkg::*;

    logic [E_W-1:0]   e_next;
    logic [VW+FB-1:0] norm;
    logic [FB:0]      m_next    [1:FB];
    logic [FB-1:0]    frac_next [1:FB];

    logic [FB:0]      m_reg    [0:FB];
    logic [FB-1:0]    frac_reg [0:FB];
    logic [E_W-1:0]   e_reg    [0:FB];
    logic             z_reg    [0:FB];

    // Exponent from the top set bit, mantissa with its top bit at FB.
    always_comb
    begin
        e_next = '0;
        for (int i = 0; i < VW; i++)
        begin
            if (v[i])
            begin
                e_next = E_W'(i);
            end
        end
        norm = {v, FB'(0)} >> e_next;
    end

    // One squaring per stage, one fraction bit per stage, MSB first.
    always_comb
    begin
        logic [2*FB+1:0] prod;
        logic [FB+1:0]   sq;
        for (int i = 1; i <= FB; i++)
        begin
            prod = (2*FB+2)'(m_reg[i-1]) * (2*FB+2)'(m_reg[i-1]);
            sq   = prod[2*FB+1:FB];
            m_next[i]    = sq[FB+1] ? sq[FB+1:1] : sq[FB:0];
            frac_next[i] = {frac_reg[i-1][FB-2:0], sq[FB+1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]    <= norm[FB:0];
            frac_reg[0] <= '0;
            e_reg[0]    <= e_next;
            z_reg[0]    <= (v == '0);
            for (int i = 1; i <= FB; i++)
            begin
                m_reg[i]    <= m_next[i];
                frac_reg[i] <= frac_next[i];
                e_reg[i]    <= e_reg[i-1];
                z_reg[i]    <= z_reg[i-1];
            end
        end
    end

    assign l = z_reg[FB] ? '0 : {e_reg[FB], frac_reg[FB]};

endmodule

### sv/sdrpq_exp2n.sv
`timescale 1ns / 1ps

module sdrpq_exp2n #(
    parameter int AW = 38
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [AW-1:0]          a,
    output logic [sdrpq_pkg::FB:0] r
);
    import sdrpq_pkg::*;

    localparam int IP_W = AW - FB;
    localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

    logic [FB:0]   h_tab  [1:FB];
    logic [FB:0]   r_next [1:FB];
    logic [FB:0]   r_reg  [1:FB];
    logic [AW-1:0] a_reg  [1:FB];
    logic [FB:0]   out_reg;
    logic [IP_W-1:0] ip;

    for (genvar k = 1; k <= FB; k++)
    begin : g_tab
        localparam logic [FB:0] HK = exp_h(k);
        assign h_tab[k] = HK;
    end

    // Stage k folds in the root for bit FB-k of the fraction.
    always_comb
    begin
        logic [2*FB+1:0] prod;
        logic [FB:0]     r_in;
        logic [AW-1:0]   a_in;
        for (int k = 1; k <= FB; k++)
        begin
            r_in = (k == 1) ? ONE : r_reg[(k == 1) ? 1 : k-1];
            a_in = (k == 1) ? a   : a_reg[(k == 1) ? 1 : k-1];
            prod = (2*FB+2)'(r_in) * (2*FB+2)'(h_tab[k]);
            r_next[k] = a_in[FB-k] ? prod[2*FB:FB] : r_in;
        end
    end

    assign ip = a_reg[FB][AW-1:FB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[1] <= r_next[1];
            a_reg[1] <= a;
            for (int k = 2; k <= FB; k++)
            begin
                r_reg[k] <= r_next[k];
                a_reg[k] <= a_reg[k-1];
            end
            out_reg <= (ip >= IP_W'(31)) ? '0 : (r_reg[FB] >> ip);
        end
    end

    assign r = out_reg;

endmodule

### sv/sdr_level_to_pq_encode_top.sv
`timescale 1ns / 1ps
// SDR level to PQ code encoder.
// Input channel: in_valid / in_ready with sdr_level (unsigned Q0.INPUT_BITS).
// Output channel: out_valid / out_ready with pq_code (unsigned Q0.OUTPUT_BITS).
// Config port: cfg_we with cfg_index / cfg_data; index 0 is the white level
// in nits, index 1 bit 0 turns the gamma + PQ path on. Write only while idle.
// Throughput: one transaction per clock, with no bubbles while the skid entry is free.
// Path: four 31-stage lanes in series, log2 squaring and exp2 multiply by turns
// (two of each; each log2 lane is a pair side by side), plus the glue stages
// between them and the output register.
// Pass-through transactions take the same path and the same latency.
// Reset clears the config (white 1 nit, HDR off), all pipeline valid bits and
// the output and skid valid flags; in_ready comes up high.
// Receiver stall: the whole pipeline advances on one enable. A two-entry
// output (register plus skid) lets the last stage drain one transaction into
// the skid while out_ready is low; in_ready drops only while the skid is full,
// and the pipeline then holds every stage in place.
module sdr_level_to_pq_encode_top #(
    parameter int INPUT_BITS  = 16,
    parameter int OUTPUT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  sdrpq_pkg::cfg_idx_t             cfg_index,
    input  logic [sdrpq_pkg::WHITE_W-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [INPUT_BITS-1:0]           sdr_level,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [OUTPUT_BITS-1:0]          pq_code
);
    import sdrpq_pkg::*;

    // Pipeline positions, counted in registers after acceptance.
    localparam int POS_LM = LOG_LAT + 5 + EXP_LAT;
    localparam int POS_PQ = POS_LM + 1 + LOG_LAT + 2 + EXP_LAT;
    localparam int SB_LEN = POS_PQ + 1;

    localparam logic [LOG_W-1:0] LOG_XMAX = log2_q(64'((64'd1 << INPUT_BITS) - 64'd1));
    localparam logic [LOG_W-1:0] LOG_PEAK = log2_q(PEAK_NITS);
    localparam logic [OUTPUT_BITS-1:0] OMAX = {OUTPUT_BITS{1'b1}};
    localparam int RES_W = FB + OUTPUT_BITS + 2;

    // Config registers.
    logic [WHITE_W-1:0] white_level_reg;
    logic               hdr_active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_level_reg <= WHITE_W'(1);
            hdr_active_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WHITE_LEVEL: white_level_reg <= cfg_data;
                CFG_HDR_ACTIVE:  hdr_active_reg  <= cfg_data[0];
                default:         hdr_active_reg  <= hdr_active_reg;
            endcase
        end
    end

    // Global pipeline enable: advance whenever the skid entry is free.
    logic en;
    logic accept;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;
    assign accept   = in_valid && en;

    // Pass-through value at the output width.
    logic [OUTPUT_BITS-1:0] pass_next;
    if (OUTPUT_BITS >= INPUT_BITS)
    begin : g_up
        assign pass_next = OUTPUT_BITS'(sdr_level) << (OUTPUT_BITS - INPUT_BITS);
    end
    else
    begin : g_dn
        assign pass_next = OUTPUT_BITS'(sdr_level >> (INPUT_BITS - OUTPUT_BITS));
    end

    // Sideband shift line: valid bits travel with the data.
    logic [SB_LEN-1:0]      valid_reg;
    side_t                  side_reg [0:SB_LEN-1];
    logic [OUTPUT_BITS-1:0] pass_reg [0:SB_LEN-1];
    side_t                  side_next;

    assign side_next.hdr  = hdr_active_reg;
    assign side_next.zero = (sdr_level == '0) || (white_level_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[SB_LEN-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            pass_reg[0] <= pass_next;
            for (int i = 1; i < SB_LEN; i++)
            begin
                side_reg[i] <= side_reg[i-1];
                pass_reg[i] <= pass_reg[i-1];
            end
        end
    end

    // log2 of the level and of the white level.
    logic [LOG_W-1:0] lx;
    logic [LOG_W-1:0] lw;

    sdrpq_log2 #(.VW(INPUT_BITS)) u_log_x (
        .clk (clk),
        .en  (en),
        .v   (sdr_level),
        .l   (lx)
    );

    sdrpq_log2 #(.VW(WHITE_W)) u_log_w (
        .clk (clk),
        .en  (en),
        .v   (white_level_reg),
        .l   (lw)
    );

    // Gamma 2.2 in the log domain: g = diff * 11 / 5, then the white scale.
    logic [39:0]          g11_reg;
    logic signed [37:0]   t1_reg, t2_reg, t3_reg;
    logic [DIV_SPLIT-1:0] nh;
    logic [DIV_SPLIT:0]   dv_next;
    logic [42:0]          q_prod;
    logic [37:0]          hi_reg;
    logic [DIV_SPLIT:0]   dv_reg;
    logic [18:0]          q0_reg;
    logic [20:0]          rem;
    logic [38:0]          g_reg;
    logic signed [40:0]   s_val;
    logic [39:0]          a_reg;
    logic [51:0]          am_prod;
    logic [AM_W-1:0]      am_reg;
    logic [LOG_W-1:0]     diff;

    assign diff    = LOG_XMAX - lx;
    assign nh      = g11_reg[39:DIV_SPLIT];
    assign dv_next = {1'b0, nh} + {1'b0, g11_reg[DIV_SPLIT-1:0]};
    assign q_prod  = 43'(dv_next) * 43'(RECIP5);
    assign rem     = dv_reg - 21'(q0_reg) * 21'd5;
    assign s_val   = {{3{t3_reg[37]}}, t3_reg} - {2'b0, g_reg};
    assign am_prod = 52'(a_reg) * 52'(M1_Q14);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g11_reg <= (40'(diff) << 3) + (40'(diff) << 1) + 40'(diff);
            t1_reg  <= $signed({2'b0, lw}) - $signed({2'b0, LOG_PEAK});
            hi_reg  <= 38'(nh) * 38'(HI5);
            dv_reg  <= dv_next;
            q0_reg  <= q_prod[42:RECIP5_SH];
            t2_reg  <= t1_reg;
            g_reg   <= 39'(hi_reg) + 39'(q0_reg) + ((rem >= 21'd5) ? 39'd1 : 39'd0);
            t3_reg  <= t2_reg;
            a_reg   <= s_val[40] ? 40'(-s_val) : '0;
            am_reg  <= am_prod[51:14];
        end
    end

    // Linear light to the m1 power.
    logic [FB:0] lm;

    sdrpq_exp2n #(.AW(AM_W)) u_exp_lm (
        .clk (clk),
        .en  (en),
        .a   (am_reg),
        .r   (lm)
    );

    // Rational part of the PQ curve.
    logic [FB:0]     lm_eff;
    logic [42:0]     pn_prod;
    logic [42:0]     pd_prod;
    logic [ND_W-1:0] num_reg;
    logic [ND_W-1:0] den_reg;

    assign lm_eff  = side_reg[POS_LM-1].zero ? '0 : lm;
    assign pn_prod = 43'(lm_eff) * 43'(C2_Q7);
    assign pd_prod = 43'(lm_eff) * 43'(C3_Q7);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= NUM_BASE + ND_W'(pn_prod[42:7]);
            den_reg <= DEN_BASE + ND_W'(pd_prod[42:7]);
        end
    end

    logic [LOG_W-1:0] lnum;
    logic [LOG_W-1:0] lden;

    sdrpq_log2 #(.VW(ND_W)) u_log_num (
        .clk (clk),
        .en  (en),
        .v   (num_reg),
        .l   (lnum)
    );

    sdrpq_log2 #(.VW(ND_W)) u_log_den (
        .clk (clk),
        .en  (en),
        .v   (den_reg),
        .l   (lden)
    );

    // Ratio to the m2 power, clamp at zero.
    logic signed [LOG_W:0] d_val;
    logic [LOG_W-1:0]      d_reg;
    logic [47:0]           dm_prod;
    logic [DM_W-1:0]       dm_reg;

    assign d_val   = $signed({1'b0, lden}) - $signed({1'b0, lnum});
    assign dm_prod = 48'(d_reg) * 48'(M2_Q5);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg  <= d_val[LOG_W] ? '0 : d_val[LOG_W-1:0];
            dm_reg <= dm_prod[47:5];
        end
    end

    logic [FB:0] pq_frac;

    sdrpq_exp2n #(.AW(DM_W)) u_exp_pq (
        .clk (clk),
        .en  (en),
        .a   (dm_reg),
        .r   (pq_frac)
    );

    // Scale to the output width with rounding, saturate, pick pass-through.
    logic [RES_W-1:0]       res_prod;
    logic [RES_W-FB-1:0]    res_full;
    logic [OUTPUT_BITS-1:0] res_next;
    logic [OUTPUT_BITS-1:0] res_reg;

    assign res_prod = RES_W'(pq_frac) * RES_W'(OMAX) + (RES_W'(1) << (FB - 1));
    assign res_full = res_prod[RES_W-1:FB];

    always_comb
    begin
        if (!side_reg[POS_PQ-1].hdr)
        begin
            res_next = pass_reg[POS_PQ-1];
        end
        else if (res_full > (RES_W-FB)'(OMAX))
        begin
            res_next = OMAX;
        end
        else
        begin
            res_next = res_full[OUTPUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    // Output register plus one skid entry.
    logic                   push;
    logic                   out_valid_reg;
    logic [OUTPUT_BITS-1:0] out_data_reg;
    logic [OUTPUT_BITS-1:0] skid_data_reg;

    assign push = en && valid_reg[SB_LEN-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ready)
        begin
            // Hold the output; park an arriving transaction in the skid.
            if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (push)
            begin
                skid_data_reg <= res_reg;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pq_code   = out_data_reg;

endmodule

### sv/sdrpq_check.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdrpq_check #(
    parameter int OUTPUT_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [OUTPUT_BITS-1:0] pq_code
);

    `SDRPQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(pq_code), "output transaction changed while stalled")
    `SDRPQ_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !out_valid && in_ready, "not idle in reset")
    `SDRPQ_ASSERT(a_ready_low, clk, rst_n, !in_ready |-> out_valid, "input stalled with empty output")
    `SDRPQ_ASSERT(a_ready_fall, clk, rst_n, $fell(in_ready) |-> $past(out_valid && !out_ready), "input stalled without output stall")

endmodule

bind sdr_level_to_pq_encode_top sdrpq_check #(.OUTPUT_BITS(OUTPUT_BITS)) u_sdrpq_check (.*);

### test/pq_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the config port, predicts each PQ code and
// compares it with what leaves the block.
module pq_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  sdrpq_pkg::cfg_idx_t           cfg_index,
    input  logic [sdrpq_pkg::WHITE_W-1:0] cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [15:0]                   sdr_level,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [15:0]                   pq_code,
    output int                            fail_count,
    output int                            pending
);
    import sdrpq_pkg::*;

    localparam int QF = 30;

    logic [13:0] white_nits;
    logic        hdr_on;
    logic [15:0] pq_queue[$];
    logic [63:0] root_tab[0:QF];

    function automatic logic [63:0] sqrt_floor(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint log2_fixed(input logic [63:0] v);
        int          e;
        logic [63:0] m;
        logic [63:0] fr;
        if (v == 0)
        begin
            return 0;
        end
        e = 63;
        while (v[e] == 1'b0)
        begin
            e--;
        end
        m = (e > QF) ? (v >> (e - QF)) : (v << (QF - e));
        fr = 0;
        for (int i = 0; i < QF; i++)
        begin
            m = (m * m) >> QF;
            fr = fr << 1;
            if (m >= (64'd2 << QF))
            begin
                m = m >> 1;
                fr[0] = 1'b1;
            end
        end
        return (longint'(e) << QF) | longint'(fr);
    endfunction

    function automatic logic [63:0] pow2_neg(input logic [63:0] a);
        logic [63:0] r;
        logic [63:0] ip;
        r = 64'd1 << QF;
        ip = a >> QF;
        for (int k = 1; k <= QF; k++)
        begin
            if (a[QF-k])
            begin
                r = (r * root_tab[k]) >> QF;
            end
        end
        if (ip >= 31)
        begin
            return 0;
        end
        return r >> ip;
    endfunction

    function automatic logic [15:0] predict_pq(input logic [15:0] level);
        logic [63:0] lin;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] p;
        logic [63:0] res;
        logic [63:0] g;
        logic [63:0] a;
        longint      s;
        longint      d;
        if (!hdr_on)
        begin
            return level;
        end
        lin = 0;
        if (level != 0 && white_nits != 0)
        begin
            g = 64'(log2_fixed(64'hFFFF) - log2_fixed(64'(level)));
            g = g * 11 / 5;
            s = log2_fixed(64'(white_nits)) - log2_fixed(64'd10000) - longint'(g);
            a = (s < 0) ? 64'(-s) : 64'd0;
            lin = pow2_neg(a * 2610 / 16384);
        end
        num = (64'd3424 << (QF - 12)) + ((lin * 2413) >> 7);
        den = (64'd1 << QF) + ((lin * 2392) >> 7);
        d = log2_fixed(den) - log2_fixed(num);
        if (d < 0)
        begin
            d = 0;
        end
        p = pow2_neg(64'(d) * 2523 / 32);
        res = (p * 64'hFFFF + (64'd1 << (QF - 1))) >> QF;
        if (res > 64'hFFFF)
        begin
            res = 64'hFFFF;
        end
        return res[15:0];
    endfunction

    initial
    begin
        root_tab[0] = 64'd1 << (QF - 1);
        for (int k = 1; k <= QF; k++)
        begin
            root_tab[k] = sqrt_floor(root_tab[k-1] << QF);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_nits <= 14'd1;
            hdr_on     <= 1'b0;
            fail_count <= 0;
            pending    <= 0;
            pq_queue.delete();
        end
        else
        begin
            // Config writes land after any transaction in flight was predicted.
            if (cfg_we)
            begin
                if (cfg_index == CFG_WHITE_LEVEL)
                begin
                    white_nits <= cfg_data;
                end
                else
                begin
                    hdr_on <= cfg_data[0];
                end
            end
            if (in_valid && in_ready)
            begin
                pq_queue.push_back(predict_pq(sdr_level));
            end
            if (out_valid && out_ready)
            begin
                if (pq_queue.size() == 0)
                begin
                    $error("pq_code: unexpected result %0d", pq_code);
                    fail_count <= fail_count + 1;
                end
                else if (pq_queue[0] !== pq_code)
                begin
                    $error("pq_code: expected %0d actual %0d", pq_queue[0], pq_code);
                    fail_count <= fail_count + 1;
                    void'(pq_queue.pop_front());
                end
                else
                begin
                    void'(pq_queue.pop_front());
                end
            end
            pending <= pq_queue.size();
        end
    end
endmodule

### test/tb.sv
`timescale 1ns / 1ps

// Testbench top: drives levels and config writes into the PQ encoder and
// gives the verdict. Prediction and comparison live in pq_checker.
module tb;
    import sdrpq_pkg::*;

    localparam int LATENCY   = 134;
    localparam int STALL_LIM = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [13:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] sdr_level;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] pq_code;
    int          fail_count;
    int          pending;
    bit          hold_off;
    int          idle_cycles;

    sdr_level_to_pq_encode_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .sdr_level(sdr_level), .out_valid(out_valid), .out_ready(out_ready),
        .pq_code(pq_code)
    );

    pq_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .sdr_level(sdr_level), .out_valid(out_valid), .out_ready(out_ready),
        .pq_code(pq_code), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Offer one level and hold it until the transaction is accepted. Valid stays
    // up for the next call; drop it only for an idle gap or in drain.
    task automatic send_level(input logic [15:0] level, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sdr_level <= level;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid, wait for every expected PQ code, then let the pipeline settle.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [13:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Levels biased toward the ends of the range, where the curve bends most.
    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 15));
            1: return 16'($urandom_range(65520, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random stalls per result, or one long hold-off when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            idle_cycles <= 0;
        end
        else if (hold_off)
        begin
            out_ready <= 1'b0;
        end
        else if (idle_cycles > 0)
        begin
            out_ready   <= 1'b0;
            idle_cycles <= idle_cycles - 1;
        end
        else if (out_valid && out_ready)
        begin
            idle_cycles <= $urandom_range(0, 9);
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= STALL_LIM)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [13:0] whites[6];
        logic [15:0] edges[10];
        whites = '{14'd1, 14'd100, 14'd203, 14'd10000, 14'd16383, 14'd0};
        edges = '{16'd0, 16'd1, 16'd2, 16'd255, 16'h5555, 16'hAAAA,
                  16'h8000, 16'h7FFF, 16'hFFFE, 16'hFFFF};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_WHITE_LEVEL;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sdr_level = '0;
        hold_off  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pass-through at reset config, then each listed white level with HDR on.
        foreach (edges[i]) send_level(edges[i], 1'b0);
        drain();
        write_reg(CFG_HDR_ACTIVE, 14'h3FFF);
        foreach (whites[w])
        begin
            write_reg(CFG_WHITE_LEVEL, whites[w]);
            send_level(16'd0, 1'b0);
            send_level(16'hFFFF, 1'b0);
            send_level(16'h8000, 1'b0);
            drain();
        end

        // Long receiver hold-off while the sender keeps offering.
        write_reg(CFG_WHITE_LEVEL, 14'd203);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                repeat (200) send_level(pick_level(), 1'b0);
            end
        join
        drain();

        // Random phases, each with its own setting.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_WHITE_LEVEL, (ph == 5) ? 14'd10000 : 14'($urandom_range(1, 16383)));
            write_reg(CFG_HDR_ACTIVE, 14'($urandom));
            for (int n = 0; n < 85; n++)
            begin
                send_level(pick_level(), n < 30 ? 1'b0 : 1'b1);
            end
            drain();
        end

        if (fail_count == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
